FILE: rtl/assert_macros.svh
// Assertion macros shared by the line sensor position error RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define LSPE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define LSPE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

FILE: rtl/lspe_pkg.sv
// Package for the line sensor position error block: widths, masks,
// register indexes and turn direction codes. Depends on nothing.
package lspe_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int WEIGHT_W     = 8;
    localparam int MAG_W        = 10;
    localparam int POS_W        = 11;
    localparam int ALU_W        = 12;
    localparam int DIV_STEPS    = 11;
    localparam int STEP_W       = 4;
    localparam int CNT_W        = 4;
    localparam int REM_W        = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;

    localparam logic [7:0] MIDDLE_SIX_MASK  = 8'h7E;
    localparam logic [7:0] CENTRE_FOUR_MASK = 8'b0011_1100;
    localparam logic [7:0] LEFT_EDGE_MASK   = 8'b1100_0000;
    localparam logic [7:0] RIGHT_EDGE_MASK  = 8'b0000_0011;

    localparam logic [CFG_DATA_W-1:0] WEIGHTS_RESET   = 64'h2319_0F07_F9F1_E7DD;
    localparam logic [MAG_W-1:0]      MAGNITUDE_RESET = 10'd100;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_WEIGHTS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_MAGNITUDE = 2'd1;

    // Turn direction, two's complement: -1, 0, +1. The remaining code is unused.
    localparam logic [1:0] DIR_NONE    = 2'b00;
    localparam logic [1:0] DIR_POS     = 2'b01;
    localparam logic [1:0] DIR_NEG     = 2'b11;
    localparam logic [1:0] DIR_INVALID = 2'b10;

endpackage

FILE: rtl/line_sensor_position_error_top.sv
// Top level of the line sensor position error block: sequencer, state
// and output register around the shared adder. Depends on lspe_pkg,
// lspe_addsub and assert_macros.svh.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_tvalid/s_tready   s_tdata: sensor_bits
//  m_        out        m_tvalid/m_tready   m_tdata: position, m_tuser: flags
//  cfg_      in         cfg_wr_en           cfg_index, cfg_wdata
//
// After the accept, a held turn passes through the sign step to the load of
// the output register; an empty reading goes straight to that load, or
// through the sign step first when it latches a turn. A weighted mean
// accumulates the weights one sensor per cycle, takes the magnitude, runs
// 11 restoring division steps, restores the sign and loads the output
// register, all on the single adder.
// The input is ready only while the sequencer is idle; a finished result
// waits in the output register, so the next item can be taken and worked
// on while the previous result is stalled. The load cycle itself waits as
// long as the output register is full and m_tready is low. aresetn is
// synchronous and active low and returns both configuration registers, the
// previous reading and the turn direction to their reset values.
`include "assert_macros.svh"

module line_sensor_position_error_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] sensor_bits
    // Result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // [10:0] position, rest zero
    output logic [1:0]                          m_tuser,   // [0] line_lost, [1] holding_turn
    // Configuration writes
    input  logic                                cfg_wr_en,
    input  logic [lspe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lspe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ACC  = 6'b000010,
        ST_ABS  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_NEG  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    localparam int ALU_W = lspe_pkg::ALU_W;
    localparam int POS_W = lspe_pkg::POS_W;

    state_t state_reg, state_next;

    logic [lspe_pkg::CFG_DATA_W-1:0] weights_reg, weights_next;
    logic [lspe_pkg::MAG_W-1:0]      mag_reg, mag_next;
    logic [7:0]                      prev_reg, prev_next;
    logic [1:0]                      dir_reg, dir_next;

    logic [7:0]                      line_reg, line_next;
    logic [ALU_W-1:0]                sum_reg, sum_next;
    logic [lspe_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [lspe_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [POS_W-1:0]                dvd_reg, dvd_next;
    logic [lspe_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic                            neg_reg, neg_next;
    logic [POS_W-1:0]                res_pos_reg, res_pos_next;
    logic                            res_lost_reg, res_lost_next;
    logic                            res_hold_reg, res_hold_next;

    logic                            m_valid_reg, m_valid_next;
    logic [POS_W-1:0]                m_pos_reg, m_pos_next;
    logic                            m_lost_reg, m_lost_next;
    logic                            m_hold_reg, m_hold_next;

    logic [ALU_W-1:0]                alu_a, alu_b, alu_y;
    logic                            alu_sub;

    logic [2:0]                      bit_idx;
    logic                            bit_set;
    logic [lspe_pkg::WEIGHT_W-1:0]   weight_sel;
    logic [lspe_pkg::REM_W:0]        trial;
    logic                            prev_left, prev_right;

    logic                            out_lost, out_hold, out_mean, out_in_range;
    logic                            dir_invalid;

    lspe_addsub u_addsub (
        .a_i   (alu_a),
        .b_i   (alu_b),
        .sub_i (alu_sub),
        .y_o   (alu_y)
    );

    assign bit_idx    = step_reg[2:0];
    assign bit_set    = line_reg[bit_idx];
    assign weight_sel = weights_reg[{bit_idx, 3'b000} +: lspe_pkg::WEIGHT_W];
    assign trial      = {rem_reg, dvd_reg[POS_W-1]};
    assign prev_left  = (prev_reg & lspe_pkg::LEFT_EDGE_MASK) != 8'd0;
    assign prev_right = (prev_reg & lspe_pkg::RIGHT_EDGE_MASK) != 8'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16-POS_W){1'b0}}, m_pos_reg};
    assign m_tuser  = {m_hold_reg, m_lost_reg};

    always_comb begin
        state_next    = state_reg;
        weights_next  = weights_reg;
        mag_next      = mag_reg;
        prev_next     = prev_reg;
        dir_next      = dir_reg;
        line_next     = line_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        step_next     = step_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        res_pos_next  = res_pos_reg;
        res_lost_next = res_lost_reg;
        res_hold_next = res_hold_reg;
        m_valid_next  = m_valid_reg;
        m_pos_next    = m_pos_reg;
        m_lost_next   = m_lost_reg;
        m_hold_next   = m_hold_reg;
        alu_a         = '0;
        alu_b         = '0;
        alu_sub       = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_index)
                lspe_pkg::REG_BIT_WEIGHTS: begin
                    weights_next = cfg_wdata;
                end
                lspe_pkg::REG_TURN_MAGNITUDE: begin
                    mag_next = cfg_wdata[lspe_pkg::MAG_W-1:0];
                end
                default: begin
                end
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    prev_next = s_tdata;
                    if (dir_reg != lspe_pkg::DIR_NONE
                        && (s_tdata & lspe_pkg::MIDDLE_SIX_MASK) == 8'd0) begin
                        // Turn still held: the middle sensors are clear.
                        dvd_next      = {1'b0, mag_reg};
                        neg_next      = (dir_reg == lspe_pkg::DIR_NEG);
                        res_lost_next = 1'b0;
                        res_hold_next = 1'b1;
                        state_next    = ST_NEG;
                    end else begin
                        dir_next = lspe_pkg::DIR_NONE;
                        if (s_tdata == 8'd0) begin
                            res_lost_next = 1'b0;
                            if (prev_reg == 8'd0
                                || (prev_reg & lspe_pkg::CENTRE_FOUR_MASK) != 8'd0) begin
                                res_pos_next  = '0;
                                res_lost_next = 1'b1;
                                res_hold_next = 1'b0;
                                state_next    = ST_DONE;
                            end else if (prev_left && !prev_right) begin
                                dir_next      = lspe_pkg::DIR_POS;
                                dvd_next      = {1'b0, mag_reg};
                                neg_next      = 1'b0;
                                res_hold_next = 1'b1;
                                state_next    = ST_NEG;
                            end else if (prev_right && !prev_left) begin
                                dir_next      = lspe_pkg::DIR_NEG;
                                dvd_next      = {1'b0, mag_reg};
                                neg_next      = 1'b1;
                                res_hold_next = 1'b1;
                                state_next    = ST_NEG;
                            end else begin
                                // Both edges were seen: no direction to hold.
                                res_pos_next  = '0;
                                res_hold_next = 1'b0;
                                state_next    = ST_DONE;
                            end
                        end else begin
                            line_next     = s_tdata;
                            sum_next      = '0;
                            cnt_next      = '0;
                            step_next     = '0;
                            res_lost_next = 1'b0;
                            res_hold_next = 1'b0;
                            state_next    = ST_ACC;
                        end
                    end
                end
            end
            ST_ACC: begin
                // One sensor per cycle: add its weight if the bit is set.
                alu_a    = sum_reg;
                alu_b    = bit_set ? {{(ALU_W-lspe_pkg::WEIGHT_W){weight_sel[7]}}, weight_sel}
                                   : '0;
                sum_next = alu_y;
                cnt_next = cnt_reg + {{(lspe_pkg::CNT_W-1){1'b0}}, bit_set};
                if (step_reg == lspe_pkg::STEP_W'(lspe_pkg::SENSOR_COUNT - 1)) begin
                    step_next  = '0;
                    state_next = ST_ABS;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_ABS: begin
                alu_a      = '0;
                alu_b      = sum_reg;
                alu_sub    = sum_reg[ALU_W-1];
                dvd_next   = alu_y[POS_W-1:0];
                neg_next   = sum_reg[ALU_W-1];
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                alu_a   = {{(ALU_W-lspe_pkg::REM_W-1){1'b0}}, trial};
                alu_b   = {{(ALU_W-lspe_pkg::CNT_W){1'b0}}, cnt_reg};
                alu_sub = 1'b1;
                if (!alu_y[ALU_W-1]) begin
                    rem_next = alu_y[lspe_pkg::REM_W-1:0];
                    dvd_next = {dvd_reg[POS_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[lspe_pkg::REM_W-1:0];
                    dvd_next = {dvd_reg[POS_W-2:0], 1'b0};
                end
                if (step_reg == lspe_pkg::STEP_W'(lspe_pkg::DIV_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_NEG;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_NEG: begin
                alu_a        = '0;
                alu_b        = {{(ALU_W-POS_W){1'b0}}, dvd_reg};
                alu_sub      = neg_reg;
                res_pos_next = alu_y[POS_W-1:0];
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_pos_next   = res_pos_reg;
                    m_lost_next  = res_lost_reg;
                    m_hold_next  = res_hold_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            weights_reg <= lspe_pkg::WEIGHTS_RESET;
            mag_reg     <= lspe_pkg::MAGNITUDE_RESET;
            prev_reg    <= 8'd0;
            dir_reg     <= lspe_pkg::DIR_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            weights_reg <= weights_next;
            mag_reg     <= mag_next;
            prev_reg    <= prev_next;
            dir_reg     <= dir_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        line_reg     <= line_next;
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        step_reg     <= step_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        res_pos_reg  <= res_pos_next;
        res_lost_reg <= res_lost_next;
        res_hold_reg <= res_hold_next;
        m_pos_reg    <= m_pos_next;
        m_lost_reg   <= m_lost_next;
        m_hold_reg   <= m_hold_next;
    end

    // Views of the output register used by the checks below.
    assign out_lost     = m_valid_reg && m_lost_reg;
    assign out_hold     = m_valid_reg && m_hold_reg;
    assign out_mean     = m_valid_reg && !m_lost_reg && !m_hold_reg;
    assign out_in_range = ($signed(m_pos_reg) >= -128) && ($signed(m_pos_reg) <= 127);
    assign dir_invalid  = (dir_reg == lspe_pkg::DIR_INVALID);

    // A held turn is never reported together with a lost line.
    `LSPE_ASSERT_NEVER(a_lost_hold, aclk, aresetn, out_lost && out_hold, "lost and held together")

    // A lost line always reports a zero position.
    `LSPE_ASSERT(a_lost_zero, aclk, aresetn, out_lost |-> m_pos_reg == '0, "position not zero")

    // A weighted mean stays inside the range of one sensor weight.
    `LSPE_ASSERT(a_mean_range, aclk, aresetn, out_mean |-> out_in_range, "mean out of range")

    // The turn direction register only ever holds -1, 0 or +1.
    `LSPE_ASSERT_NEVER(a_dir_code, aclk, aresetn, dir_invalid, "invalid turn direction code")

endmodule

FILE: rtl/lspe_addsub.sv
// Shared adder/subtractor of the line sensor position error block.
// Depends on lspe_pkg for the datapath width.
module lspe_addsub (
    input  logic [lspe_pkg::ALU_W-1:0] a_i,
    input  logic [lspe_pkg::ALU_W-1:0] b_i,
    input  logic                       sub_i,
    output logic [lspe_pkg::ALU_W-1:0] y_o
);

    // Subtraction is a plus the one's complement of b plus one.
    assign y_o = a_i + (b_i ^ {lspe_pkg::ALU_W{sub_i}})
               + {{(lspe_pkg::ALU_W-1){1'b0}}, sub_i};

endmodule

FILE: test/tb.sv
// Self-checking testbench for line_sensor_position_error_top: sends sensor readings,
// predicts the position error, line-lost and held-turn flags, and checks every result.
// Depends on lspe_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;

    localparam int POS_W      = lspe_pkg::POS_W;
    localparam int MAG_W      = lspe_pkg::MAG_W;
    localparam int CFG_IDX_W  = lspe_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = lspe_pkg::CFG_DATA_W;
    localparam int WEIGHT_W   = lspe_pkg::WEIGHT_W;

    // Register indexes that select no register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Cycles without any handshake before the run is declared hung. This is far
    // above the slowest item of a correct run, idle bursts included.
    localparam int HANG_LIMIT = 2000;

    // Cycles allowed after the last result before the verdict.
    localparam int SETTLE_CYCLES = 30;

    // One expected result item.
    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    line_lost;
        logic                    holding_turn;
    } position_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] sensor_bits
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;          // [10:0] position, rest zero
    logic [1:0]            m_tuser;          // [0] line_lost, [1] holding_turn
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // The predictor's own copy of the registers and the block state.
    logic [CFG_DATA_W-1:0] model_weights   = lspe_pkg::WEIGHTS_RESET;
    logic [MAG_W-1:0]      model_magnitude = lspe_pkg::MAGNITUDE_RESET;
    logic [7:0]            last_reading    = '0;
    logic [1:0]            held_dir        = lspe_pkg::DIR_NONE;

    position_result_t expected_positions[$];
    int               error_count    = 0;
    int               quiet_cycles   = 0;
    bit               bursts_enabled = 1'b1;

    line_sensor_position_error_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Works out the result of one reading and advances the predicted state.
    // A held turn survives as long as the middle six sensors stay clear; an
    // empty reading looks back at the previous one to decide between line
    // lost and latching a turn toward the edge the line was last seen on.
    function automatic position_result_t predict_position(input logic [7:0] reading);
        position_result_t            result;
        logic [7:0]                  prior;
        logic signed [WEIGHT_W-1:0]  weight;
        int                          dir_val;
        int                          weight_sum;
        int                          set_count;
        prior        = last_reading;
        last_reading = reading;
        result       = '0;
        weight_sum   = 0;
        set_count    = 0;

        if (held_dir != lspe_pkg::DIR_NONE) begin
            if ((reading & lspe_pkg::MIDDLE_SIX_MASK) == 8'h00) begin
                dir_val = (held_dir == lspe_pkg::DIR_POS) ? 1 : -1;
                result.position     = POS_W'(dir_val * int'(model_magnitude));
                result.holding_turn = 1'b1;
                return result;
            end
            // The line came back into the middle: drop the turn and carry on.
            held_dir = lspe_pkg::DIR_NONE;
        end

        if (reading == 8'h00) begin
            if (prior == 8'h00 || (prior & lspe_pkg::CENTRE_FOUR_MASK) != 8'h00) begin
                result.line_lost = 1'b1;
                return result;
            end
            dir_val = (((prior & lspe_pkg::LEFT_EDGE_MASK) != 8'h00) ? 1 : 0)
                    - (((prior & lspe_pkg::RIGHT_EDGE_MASK) != 8'h00) ? 1 : 0);
            if (dir_val > 0) begin
                held_dir = lspe_pkg::DIR_POS;
            end else if (dir_val < 0) begin
                held_dir = lspe_pkg::DIR_NEG;
            end
            result.position     = POS_W'(dir_val * int'(model_magnitude));
            result.holding_turn = (held_dir != lspe_pkg::DIR_NONE);
            return result;
        end

        // Mean of the signed weights of the set sensors, truncated toward zero.
        for (int i = 0; i < lspe_pkg::SENSOR_COUNT; i++) begin
            if (reading[i]) begin
                weight     = model_weights[i*WEIGHT_W +: WEIGHT_W];
                weight_sum += int'(weight);
                set_count++;
            end
        end
        result.position = POS_W'(weight_sum / set_count);
        return result;
    endfunction

    // Sends one reading, optionally after a short idle burst. tvalid stays high
    // after the handshake so that back-to-back items need no idle gap between them.
    task automatic send_reading(input logic [7:0] reading);
        if (bursts_enabled && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= reading;
        do @(posedge aclk); while (!s_tready);
        expected_positions.push_back(predict_position(reading));
    endtask

    // Stops sending and waits until every result is back, so registers can change.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (expected_positions.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One register write, followed by an idle wait that keeps write enables apart.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == lspe_pkg::REG_BIT_WEIGHTS) begin
            model_weights = value;
        end else if (index == lspe_pkg::REG_TURN_MAGNITUDE) begin
            model_magnitude = value[MAG_W-1:0];
        end
        @(posedge aclk);
    endtask

    // Half of the readings are empty or edge-only so that turns get latched, held and
    // dropped often; the rest are single sensors and fully random readings.
    function automatic logic [7:0] random_reading();
        logic [7:0] reading;
        case ($urandom_range(0, 9))
            0, 1, 2: reading = 8'h00;
            3, 4:    reading = 8'($urandom)
                               & (lspe_pkg::LEFT_EDGE_MASK | lspe_pkg::RIGHT_EDGE_MASK);
            5:       reading = 8'h01 << $urandom_range(0, 7);
            default: reading = 8'($urandom);
        endcase
        return reading;
    endfunction

    // Walks through every branch with the reset weights and magnitude: line
    // lost from an empty history, line lost after a centre reading, turns in
    // both directions, a held turn with only the outer sensors set, a turn
    // dropped when the middle lights up, and both edges seen at once.
    task automatic test_directed_cases();
        logic [7:0] readings[25];
        readings = '{8'h00, 8'h18, 8'h00, 8'h01, 8'h00, 8'h00, 8'h81, 8'h08,
                     8'h80, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h81, 8'h00, 8'h00,
                     8'h40, 8'h00, 8'h02, 8'h7E, 8'h55, 8'hAA, 8'h03, 8'h00,
                     8'h7E};
        foreach (readings[i]) send_reading(readings[i]);
        wait_until_idle();
    endtask

    // Extreme weights and magnitudes, writes to the unused indexes, and a
    // magnitude write whose upper bits must be dropped.
    task automatic test_register_extremes();
        logic [CFG_DATA_W-1:0] weight_sets[4];
        logic [MAG_W-1:0]      magnitudes[4];
        weight_sets = '{64'h8080_8080_8080_8080, 64'h7F7F_7F7F_7F7F_7F7F,
                        64'h7F80_7F80_7F80_7F80, 64'h0000_0000_0000_0000};
        magnitudes  = '{10'd0, 10'd1023, 10'd1, 10'd512};
        for (int k = 0; k < 4; k++) begin
            write_register(lspe_pkg::REG_BIT_WEIGHTS, weight_sets[k]);
            write_register(lspe_pkg::REG_TURN_MAGNITUDE, CFG_DATA_W'(magnitudes[k]));
            send_reading(8'hFF);
            send_reading(8'h80);
            send_reading(8'h00);
            send_reading(8'h81);
            send_reading(8'h01);
            send_reading(8'h00);
            send_reading(8'h96);
            wait_until_idle();
        end
        // Neither of these may change anything; the high bits above the
        // magnitude width are ignored by the block.
        write_register(REG_SPARE_A, {CFG_DATA_W{1'b1}});
        write_register(REG_SPARE_B, 64'h5A5A_5A5A_5A5A_5A5A);
        write_register(lspe_pkg::REG_TURN_MAGNITUDE, 64'hFFFF_FFFF_FFFF_FC07);
        send_reading(8'h3C);
        send_reading(8'h02);
        send_reading(8'h00);
        send_reading(8'h00);
        send_reading(8'h80);
        send_reading(8'h00);
        wait_until_idle();
    endtask

    // Random readings over several register settings. The last phase runs
    // without idle bursts on either side.
    task automatic test_random_traffic();
        logic [MAG_W-1:0] magnitude;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       magnitude = '0;
                1:       magnitude = '1;
                default: magnitude = MAG_W'($urandom);
            endcase
            write_register(lspe_pkg::REG_BIT_WEIGHTS, {$urandom, $urandom});
            // Random bits above the magnitude width must be dropped by the block.
            write_register(lspe_pkg::REG_TURN_MAGNITUDE,
                           {$urandom, 22'($urandom), magnitude});
            if (phase == 4) begin
                bursts_enabled = 1'b0;
            end
            repeat (300) send_reading(random_reading());
            wait_until_idle();
        end
    endtask

    // Receiver: ready drops in short random bursts while bursts are enabled.
    initial begin
        forever begin
            @(posedge aclk);
            if (bursts_enabled && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Result checker and hang watchdog. Signals are sampled as they stood
    // before the edge, since every driver updates them with nonblocking writes.
    always @(posedge aclk) begin
        position_result_t expected;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_positions.size() == 0) begin
                $error("result item with no expectation: position %0d",
                       $signed(m_tdata[POS_W-1:0]));
                error_count++;
            end else begin
                expected = expected_positions.pop_front();
                if (m_tdata[POS_W-1:0] !== expected.position) begin
                    $error("position: expected %0d, actual %0d",
                           expected.position, $signed(m_tdata[POS_W-1:0]));
                    error_count++;
                end
                if (m_tuser[0] !== expected.line_lost) begin
                    $error("line_lost: expected %0b, actual %0b",
                           expected.line_lost, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== expected.holding_turn) begin
                    $error("holding_turn: expected %0b, actual %0b",
                           expected.holding_turn, m_tuser[1]);
                    error_count++;
                end
            end
        end

        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence: reset once, then the directed, register and random
    // tests in turn, then wait for the last results and give the verdict.
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_register_extremes();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (expected_positions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
